FILE: hdl/sdss_pkg.sv
// Shared types and constants of the sensor debounce and solve block.
package sdss_pkg;

    localparam int ADDR_W = 5;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

    // Item opcodes.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_FORCE = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Solve rules.
    localparam logic [1:0] MODE_ANY = 2'd0;
    localparam logic [1:0] MODE_ALL = 2'd1;
    localparam logic [1:0] MODE_SEQ = 2'd2;

    // Register indexes (word address).
    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE = 3'd1;
    localparam logic [2:0] REG_ARMING   = 3'd2;
    localparam logic [2:0] REG_LATCHING = 3'd3;
    localparam logic [2:0] REG_DECOY    = 3'd4;
    localparam logic [2:0] REG_HIGH     = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic [7:0]  pin_levels;
        logic [7:0]  sensor_index;
    } t_in_item;

    typedef struct packed {
        logic       solved;
        logic [7:0] present_mask;
        logic [7:0] latched_mask;
        logic [7:0] player_event_mask;
        logic       operator_event;
        logic       state_changed;
        logic [3:0] sequence_position;
        logic       force_accepted;
    } t_out_item;

    typedef struct packed {
        logic arm;
        logic latch;
        logic decoy;
        logic high;
    } t_lane_cfg;

    typedef struct packed {
        logic        go;
        logic [1:0]  op;
        logic [31:0] now;
        logic        pin;
        logic        hit;
    } t_lane_cmd;

    typedef struct packed {
        logic present;
        logic latched;
        logic eff;
        logic press;
        logic evt;
        logic changed;
        logic op_event;
    } t_lane_stat;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic       solved;
        logic [3:0] seq_pos;
    } t_merge_stat;

endpackage

FILE: hdl/sdss_lane.sv
// One sensor lane: debounce timer, arming, latching and per-sensor event state.
module sdss_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [15:0]           i_debounce_ms,
    input  logic                  i_mode_seq,
    input  sdss_pkg::t_lane_cfg   i_cfg,
    input  sdss_pkg::t_lane_cmd   i_cmd,
    output sdss_pkg::t_lane_stat  o_stat
);

    logic        r_armed, r_present, r_latched, r_sent, r_forced, r_level;
    logic [31:0] r_lct;
    logic        r_press, r_evt, r_changed, r_op_event;

    logic        n_armed, n_present, n_latched, n_sent, n_forced, n_level;
    logic [31:0] n_lct;
    logic        n_press, n_evt, n_changed, n_op_event;

    logic        raw;
    logic        locked;
    logic        settled;
    logic [31:0] lct_now;
    logic [31:0] elapsed;

    always_comb begin
        raw     = (i_cmd.pin == i_cfg.high);
        lct_now = (raw != r_level) ? i_cmd.now : r_lct;
        elapsed = i_cmd.now - lct_now;
        settled = (elapsed >= {16'd0, i_debounce_ms});
        locked  = r_present & r_forced;

        n_armed    = r_armed;
        n_present  = r_present;
        n_latched  = r_latched;
        n_sent     = r_sent;
        n_forced   = r_forced;
        n_level    = r_level;
        n_lct      = r_lct;
        n_press    = 1'b0;
        n_evt      = 1'b0;
        n_changed  = 1'b0;
        n_op_event = 1'b0;

        case (i_cmd.op)
            sdss_pkg::OP_TICK: begin
                if (!locked) begin
                    n_level = raw;
                    n_lct   = lct_now;
                    if (settled) begin
                        // An unarmed sensor must first read absent before it counts.
                        if (i_cfg.arm && !r_armed) begin
                            if (!raw) begin
                                n_armed = 1'b1;
                            end
                        end else begin
                            n_present = raw;
                            if (raw && !r_present) begin
                                n_press   = 1'b1;
                                n_changed = 1'b1;
                                if (i_cfg.latch) begin
                                    n_latched = 1'b1;
                                end
                                if (i_cfg.decoy) begin
                                    n_evt = 1'b1;
                                end else if (!i_mode_seq && !r_sent) begin
                                    n_evt  = 1'b1;
                                    n_sent = 1'b1;
                                end
                            end
                            if (!raw && r_present) begin
                                n_changed = 1'b1;
                            end
                        end
                    end
                end
            end
            sdss_pkg::OP_RESET: begin
                n_armed   = !i_cfg.arm;
                n_level   = raw;
                n_lct     = i_cmd.now;
                n_present = 1'b0;
                n_latched = 1'b0;
                n_sent    = 1'b0;
                n_forced  = 1'b0;
            end
            sdss_pkg::OP_FORCE: begin
                if (i_cmd.hit) begin
                    n_armed   = 1'b1;
                    n_present = 1'b1;
                    n_latched = 1'b1;
                    n_forced  = 1'b1;
                    if (!r_sent) begin
                        n_op_event = 1'b1;
                        n_sent     = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b1;
            r_present  <= 1'b0;
            r_latched  <= 1'b0;
            r_sent     <= 1'b0;
            r_forced   <= 1'b0;
            r_level    <= 1'b0;
            r_lct      <= '0;
            r_press    <= 1'b0;
            r_evt      <= 1'b0;
            r_changed  <= 1'b0;
            r_op_event <= 1'b0;
        end else if (i_cmd.go) begin
            r_armed    <= n_armed;
            r_present  <= n_present;
            r_latched  <= n_latched;
            r_sent     <= n_sent;
            r_forced   <= n_forced;
            r_level    <= n_level;
            r_lct      <= n_lct;
            r_press    <= n_press;
            r_evt      <= n_evt;
            r_changed  <= n_changed;
            r_op_event <= n_op_event;
        end
    end

    always_comb begin
        o_stat.present  = r_present;
        o_stat.latched  = r_latched;
        o_stat.eff      = i_cfg.latch ? r_latched : r_present;
        o_stat.press    = r_press;
        o_stat.evt      = r_evt;
        o_stat.changed  = r_changed;
        o_stat.op_event = r_op_event;
    end

endmodule

FILE: hdl/sdss_merge.sv
// Merging stage: walks the lanes in sensor order to run the press sequence and solve rules.
module sdss_merge #(
    parameter int NUM_SENSORS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [1:0]                i_op,
    input  logic                      i_force_ok,
    input  logic [1:0]                i_mode,
    input  logic [NUM_SENSORS-1:0]    i_press,
    input  logic [NUM_SENSORS-1:0]    i_decoy,
    input  logic [NUM_SENSORS-1:0]    i_eff,
    output sdss_pkg::t_merge_stat     o_stat,
    output logic [NUM_SENSORS-1:0]    o_seq_events
);

    localparam int CW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int SW = $clog2(NUM_SENSORS + 1);

    logic                   r_busy, r_done;
    logic [CW-1:0]          r_cnt;
    logic [SW-1:0]          r_seq, r_n;
    logic                   r_any, r_all;
    logic [NUM_SENSORS-1:0] r_sev;

    logic                   n_busy, n_done;
    logic [CW-1:0]          n_cnt;
    logic [SW-1:0]          n_seq, n_n;
    logic                   n_any, n_all;
    logic [NUM_SENSORS-1:0] n_sev;

    logic                   real_sensor;
    logic                   mode_seq;

    always_comb begin
        mode_seq    = (i_mode == sdss_pkg::MODE_SEQ);
        real_sensor = !i_decoy[r_cnt];

        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_seq  = r_seq;
        n_n    = r_n;
        n_any  = r_any;
        n_all  = r_all;
        n_sev  = r_sev;

        if (i_go) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = '0;
            n_n    = '0;
            n_any  = 1'b0;
            n_all  = 1'b1;
            n_sev  = '0;
            if (i_op == sdss_pkg::OP_RESET) begin
                n_seq = '0;
            end else if (i_op == sdss_pkg::OP_FORCE && i_force_ok && mode_seq
                         && r_seq < SW'(NUM_SENSORS)) begin
                n_seq = r_seq + 1'b1;
            end
        end else if (r_busy) begin
            n_n   = r_n + SW'(real_sensor);
            n_any = r_any | (real_sensor & i_eff[r_cnt]);
            n_all = r_all & (!real_sensor | i_eff[r_cnt]);
            // Presses are taken in sensor order; a wrong or decoy press restarts the sequence.
            if (mode_seq && i_press[r_cnt]) begin
                if (!real_sensor) begin
                    n_seq = '0;
                end else if (SW'(r_cnt) == r_seq) begin
                    n_seq        = r_seq + 1'b1;
                    n_sev[r_cnt] = 1'b1;
                end else begin
                    n_seq = '0;
                end
            end
            if (r_cnt == CW'(NUM_SENSORS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_seq  <= '0;
            r_n    <= '0;
            r_any  <= 1'b0;
            r_all  <= 1'b1;
            r_sev  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_seq  <= n_seq;
            r_n    <= n_n;
            r_any  <= n_any;
            r_all  <= n_all;
            r_sev  <= n_sev;
        end
    end

    always_comb begin
        o_stat.busy = r_busy;
        o_stat.done = r_done;
        case (i_mode)
            sdss_pkg::MODE_ANY: o_stat.solved = r_any;
            sdss_pkg::MODE_ALL: o_stat.solved = r_all && (r_n != '0);
            sdss_pkg::MODE_SEQ: o_stat.solved = (r_n != '0) && (r_seq >= r_n);
            default:            o_stat.solved = 1'b0;
        endcase
        o_stat.seq_pos = mode_seq ? 4'(r_seq) : 4'd0;
        o_seq_events   = r_sev;
    end

endmodule

FILE: hdl/sensor_debounce_sequence_solver.sv
// Top level of the sensor debounce and solve block: register port, lanes, merge and output.
//
// Input channel i_in_valid / o_in_ready carries one item: tick, reset all, force one
// sensor (or no operation), with the timestamp, the raw pin levels and a sensor index.
// Output channel o_out_valid / i_out_ready returns exactly one result item per input item.
// The APB port writes and reads the six registers at byte addresses 0, 4, ... 20;
// write it only while no item is in flight.
// On acceptance every sensor lane updates its own debounce state in the same edge.
// The merge stage then visits one sensor per cycle to step the
// ordered press sequence and to evaluate the solve rule. When the walk is done, the
// result is registered into the output register as soon as that register is free;
// the block takes no new item until then, so o_in_ready stays low during the walk.
// A result waiting in the output register does not block the next item; only a second
// finished result waits for the receiver, holding o_in_ready low meanwhile.
// Synchronous reset clears all sensor state, the sequence and the registers to their
// defaults (debounce window 50 ms, all masks zero, any-sensor rule).
module sensor_debounce_sequence_solver #(
    parameter int NUM_SENSORS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  sdss_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output sdss_pkg::t_out_item              o_out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sdss_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [1:0]          r_mode;
    logic [15:0]         r_debounce;
    logic [7:0]          r_arming, r_latching, r_decoy, r_high;
    logic                r_force_ok;
    logic                r_out_valid;
    sdss_pkg::t_out_item r_out_data;

    logic                   in_acc;
    logic                   cfg_wr;
    logic [2:0]             reg_idx;
    logic                   load_out;
    logic                   force_ok;
    logic [NUM_SENSORS-1:0] w_press, w_decoy, w_eff, w_present, w_latched, w_evt;
    logic [NUM_SENSORS-1:0] w_changed, w_op_event, w_seq_events, w_all_events;
    logic [7:0]             w_present8, w_latched8, w_events8;
    sdss_pkg::t_lane_stat   w_stat [NUM_SENSORS];
    sdss_pkg::t_merge_stat  m_stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= sdss_pkg::MODE_ANY;
            r_debounce <= sdss_pkg::DEBOUNCE_RESET;
            r_arming   <= '0;
            r_latching <= '0;
            r_decoy    <= '0;
            r_high     <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                sdss_pkg::REG_MODE:     r_mode     <= pwdata[1:0];
                sdss_pkg::REG_DEBOUNCE: r_debounce <= pwdata[15:0];
                sdss_pkg::REG_ARMING:   r_arming   <= pwdata[7:0];
                sdss_pkg::REG_LATCHING: r_latching <= pwdata[7:0];
                sdss_pkg::REG_DECOY:    r_decoy    <= pwdata[7:0];
                sdss_pkg::REG_HIGH:     r_high     <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            sdss_pkg::REG_MODE:     prdata = {30'd0, r_mode};
            sdss_pkg::REG_DEBOUNCE: prdata = {16'd0, r_debounce};
            sdss_pkg::REG_ARMING:   prdata = {24'd0, r_arming};
            sdss_pkg::REG_LATCHING: prdata = {24'd0, r_latching};
            sdss_pkg::REG_DECOY:    prdata = {24'd0, r_decoy};
            sdss_pkg::REG_HIGH:     prdata = {24'd0, r_high};
            default:                prdata = '0;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign force_ok   = (i_in_data.opcode == sdss_pkg::OP_FORCE)
                        && (i_in_data.sensor_index < 8'(NUM_SENSORS));

    // Sensors beyond the eighth see pin level 0 and clear mask bits.
    genvar gi;
    generate
        for (gi = 0; gi < NUM_SENSORS; gi++) begin : g_lane
            sdss_pkg::t_lane_cfg l_cfg;
            sdss_pkg::t_lane_cmd l_cmd;
            if (gi < 8) begin : g_wired
                assign l_cfg.arm   = r_arming[gi];
                assign l_cfg.latch = r_latching[gi];
                assign l_cfg.decoy = r_decoy[gi];
                assign l_cfg.high  = r_high[gi];
                assign l_cmd.pin   = i_in_data.pin_levels[gi];
            end else begin : g_blank
                assign l_cfg = '0;
                assign l_cmd.pin = 1'b0;
            end
            assign l_cmd.go  = in_acc;
            assign l_cmd.op  = i_in_data.opcode;
            assign l_cmd.now = i_in_data.now_ms;
            assign l_cmd.hit = (i_in_data.sensor_index == 8'(gi));

            sdss_lane u_lane (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_debounce_ms (r_debounce),
                .i_mode_seq    (r_mode == sdss_pkg::MODE_SEQ),
                .i_cfg         (l_cfg),
                .i_cmd         (l_cmd),
                .o_stat        (w_stat[gi])
            );

            assign w_press[gi]    = w_stat[gi].press;
            assign w_decoy[gi]    = l_cfg.decoy;
            assign w_eff[gi]      = w_stat[gi].eff;
            assign w_present[gi]  = w_stat[gi].present;
            assign w_latched[gi]  = w_stat[gi].latched;
            assign w_evt[gi]      = w_stat[gi].evt;
            assign w_changed[gi]  = w_stat[gi].changed;
            assign w_op_event[gi] = w_stat[gi].op_event;
        end
    endgenerate

    sdss_merge #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (in_acc),
        .i_op         (i_in_data.opcode),
        .i_force_ok   (force_ok),
        .i_mode       (r_mode),
        .i_press      (w_press),
        .i_decoy      (w_decoy),
        .i_eff        (w_eff),
        .o_stat       (m_stat),
        .o_seq_events (w_seq_events)
    );

    assign w_all_events = w_evt | w_seq_events;

    generate
        for (gi = 0; gi < 8; gi++) begin : g_out_bit
            if (gi < NUM_SENSORS) begin : g_on
                assign w_present8[gi] = w_present[gi];
                assign w_latched8[gi] = w_latched[gi];
                assign w_events8[gi]  = w_all_events[gi];
            end else begin : g_off
                assign w_present8[gi] = 1'b0;
                assign w_latched8[gi] = 1'b0;
                assign w_events8[gi]  = 1'b0;
            end
        end
    endgenerate

    assign load_out = (r_state == S_WALK) && m_stat.done && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_WALK;
            S_WALK:  if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_force_ok  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_force_ok <= force_ok;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data.solved            <= m_stat.solved;
            r_out_data.present_mask      <= w_present8;
            r_out_data.latched_mask      <= w_latched8;
            r_out_data.player_event_mask <= w_events8;
            r_out_data.operator_event    <= |w_op_event;
            r_out_data.state_changed     <= |w_changed;
            r_out_data.sequence_position <= m_stat.seq_pos;
            r_out_data.force_accepted    <= r_force_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_no_accept_while_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_stat.busy |-> !o_in_ready)
        else $error("input accepted while the merge walk is running");

    a_load_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> !m_stat.busy && (r_state == S_WALK))
        else $error("result loaded before the merge walk finished");

    a_force_no_player_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.force_accepted && (o_out_data.player_event_mask != 8'd0)))
        else $error("force result carries player events");

    a_walk_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> m_stat.busy && !m_stat.done)
        else $error("merge walk did not start after an accepted item");
`endif

endmodule

FILE: test/tb_sensor_debounce_sequence_solver.sv
// Self-checking testbench for the sensor debounce and sequence solve block.
module tb_sensor_debounce_sequence_solver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SENSORS = 8;
    localparam int N_PHASES = 9;
    localparam int POLLS_PER_PHASE = 145;
    localparam int CYCLE_LIMIT = 600000;
    // The block accepts mode 3 but never solves under it.
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    sdss_pkg::t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    sdss_pkg::t_out_item o_out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [sdss_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    sensor_debounce_sequence_solver #(
        .NUM_SENSORS(N_SENSORS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #6 i_clk = ~i_clk;

    // Register shadow, kept equal to the block's registers.
    logic [1:0]  cfg_mode = sdss_pkg::MODE_ANY;
    logic [15:0] cfg_deb = sdss_pkg::DEBOUNCE_RESET;
    logic [7:0]  cfg_arm = '0;
    logic [7:0]  cfg_latch = '0;
    logic [7:0]  cfg_decoy = '0;
    logic [7:0]  cfg_high = '0;

    // Predicted sensor state.
    logic [7:0]  st_armed = 8'hFF;
    logic [7:0]  st_present = '0;
    logic [7:0]  st_latched = '0;
    logic [7:0]  st_evsent = '0;
    logic [7:0]  st_forced = '0;
    logic [7:0]  st_level = '0;
    logic [31:0] st_changed_at [N_SENSORS] = '{default: '0};
    int          st_seq = 0;

    sdss_pkg::t_in_item  pending_polls [$];
    sdss_pkg::t_out_item expected_reports [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int results_seen = 0;
    int polls_made = 0;
    int cycle_count = 0;

    // Stimulus time base and pin picture.
    logic [31:0] clock_ms = '0;
    logic [7:0]  pin_state = '0;

    function automatic logic solved_now();
        int n;
        int i;
        logic eff;
        n = 0;
        for (i = 0; i < N_SENSORS; i++)
            if (!cfg_decoy[i]) n++;
        if (cfg_mode == sdss_pkg::MODE_SEQ) return (n > 0) && (st_seq >= n);
        if (cfg_mode != sdss_pkg::MODE_ANY && cfg_mode != sdss_pkg::MODE_ALL) return 1'b0;
        for (i = 0; i < N_SENSORS; i++) begin
            if (cfg_decoy[i]) continue;
            eff = cfg_latch[i] ? st_latched[i] : st_present[i];
            if (cfg_mode == sdss_pkg::MODE_ANY && eff) return 1'b1;
            if (cfg_mode == sdss_pkg::MODE_ALL && !eff) return 1'b0;
        end
        return (cfg_mode == sdss_pkg::MODE_ALL) && (n > 0);
    endfunction

    function automatic sdss_pkg::t_out_item debounce_and_solve(sdss_pkg::t_in_item it);
        sdss_pkg::t_out_item r;
        logic raw;
        logic was;
        logic [31:0] elapsed;
        int i;
        r = '0;
        case (it.opcode)
            sdss_pkg::OP_TICK: begin
                for (i = 0; i < N_SENSORS; i++) begin
                    // A forced sensor stays locked while it reads present.
                    if (st_present[i] && st_forced[i]) continue;
                    raw = (it.pin_levels[i] == cfg_high[i]);
                    if (raw != st_level[i]) begin
                        st_level[i] = raw;
                        st_changed_at[i] = it.now_ms;
                    end
                    elapsed = it.now_ms - st_changed_at[i];
                    if (elapsed < 32'(cfg_deb)) continue;
                    if (cfg_arm[i] && !st_armed[i]) begin
                        if (!raw) st_armed[i] = 1'b1;
                        continue;
                    end
                    was = st_present[i];
                    st_present[i] = raw;
                    if (raw && !was) begin
                        r.state_changed = 1'b1;
                        if (cfg_latch[i]) st_latched[i] = 1'b1;
                        if (cfg_decoy[i]) begin
                            r.player_event_mask[i] = 1'b1;
                            if (cfg_mode == sdss_pkg::MODE_SEQ) st_seq = 0;
                        end else if (cfg_mode == sdss_pkg::MODE_SEQ) begin
                            if (i == st_seq) begin
                                st_seq++;
                                r.player_event_mask[i] = 1'b1;
                            end else begin
                                st_seq = 0;
                            end
                        end else if (!st_evsent[i]) begin
                            r.player_event_mask[i] = 1'b1;
                            st_evsent[i] = 1'b1;
                        end
                    end
                    if (!raw && was) r.state_changed = 1'b1;
                end
            end
            sdss_pkg::OP_RESET: begin
                st_armed = ~cfg_arm;
                st_level = ~(it.pin_levels ^ cfg_high);
                for (i = 0; i < N_SENSORS; i++) st_changed_at[i] = it.now_ms;
                st_present = '0;
                st_latched = '0;
                st_evsent = '0;
                st_forced = '0;
                st_seq = 0;
            end
            sdss_pkg::OP_FORCE: begin
                if (it.sensor_index < N_SENSORS) begin
                    i = it.sensor_index;
                    r.force_accepted = 1'b1;
                    st_armed[i] = 1'b1;
                    st_present[i] = 1'b1;
                    st_latched[i] = 1'b1;
                    st_forced[i] = 1'b1;
                    if (cfg_mode == sdss_pkg::MODE_SEQ && st_seq < N_SENSORS) st_seq++;
                    if (!st_evsent[i]) begin
                        r.operator_event = 1'b1;
                        st_evsent[i] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.solved = solved_now();
        r.present_mask = st_present;
        r.latched_mask = st_latched;
        r.sequence_position = (cfg_mode == sdss_pkg::MODE_SEQ) ? 4'(st_seq) : 4'd0;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic compare_report(input sdss_pkg::t_out_item got,
                                  input sdss_pkg::t_out_item want);
        check_field("solved", 8'(got.solved), 8'(want.solved));
        check_field("present_mask", got.present_mask, want.present_mask);
        check_field("latched_mask", got.latched_mask, want.latched_mask);
        check_field("player_event_mask", got.player_event_mask, want.player_event_mask);
        check_field("operator_event", 8'(got.operator_event), 8'(want.operator_event));
        check_field("state_changed", 8'(got.state_changed), 8'(want.state_changed));
        check_field("sequence_position", 8'(got.sequence_position),
                    8'(want.sequence_position));
        check_field("force_accepted", 8'(got.force_accepted), 8'(want.force_accepted));
    endtask

    // Sender: predicts each item as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_reports.push_back(debounce_and_solve(i_in_data));
            if (!i_in_valid || o_in_ready) begin
                if (pending_polls.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_polls.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_reports.size() == 0)
                    report_mismatch("result arrived with no item pending");
                else
                    compare_report(o_out_data, expected_reports.pop_front());
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sensor_debounce_sequence_solver regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            sdss_pkg::REG_MODE:     cfg_mode = val[1:0];
            sdss_pkg::REG_DEBOUNCE: cfg_deb = val[15:0];
            sdss_pkg::REG_ARMING:   cfg_arm = val[7:0];
            sdss_pkg::REG_LATCHING: cfg_latch = val[7:0];
            sdss_pkg::REG_DECOY:    cfg_decoy = val[7:0];
            sdss_pkg::REG_HIGH:     cfg_high = val[7:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_polls.size() != 0 || i_in_valid || expected_reports.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic push_item(input logic [1:0] op, input logic [31:0] now,
                             input logic [7:0] pins, input logic [7:0] idx);
        sdss_pkg::t_in_item it;
        it.opcode = op;
        it.now_ms = now;
        it.pin_levels = pins;
        it.sensor_index = idx;
        pending_polls.push_back(it);
        if (op != sdss_pkg::OP_NOP) polls_made++;
    endtask

    task automatic push_tick();
        push_item(sdss_pkg::OP_TICK, clock_ms, pin_state, 8'($urandom_range(255)));
    endtask

    // Applies a new pin picture and polls just short of and at the window, and at random past it.
    task automatic hold_pins(input logic [7:0] pins);
        logic [31:0] base;
        pin_state = pins;
        clock_ms += $urandom_range(3);
        base = clock_ms;
        push_tick();
        if (cfg_deb > 1) begin
            clock_ms = base + 32'(cfg_deb) - 1;
            push_tick();
        end
        clock_ms = base + 32'(cfg_deb);
        push_tick();
        if ($urandom_range(1)) begin
            clock_ms += $urandom_range(5);
            push_tick();
        end
    endtask

    task automatic press_sensor(input int s, input bit release_after);
        logic [7:0] p;
        p = pin_state;
        p[s] = cfg_high[s];
        hold_pins(p);
        if (release_after) begin
            p[s] = ~cfg_high[s];
            hold_pins(p);
        end
    endtask

    // Short glitches that mostly stay inside the stability window.
    task automatic chatter(input int s);
        int n;
        int k;
        n = $urandom_range(4, 1);
        for (k = 0; k < n; k++) begin
            pin_state[s] = ~pin_state[s];
            clock_ms += $urandom_range(cfg_deb / 2);
            push_tick();
        end
    endtask

    initial begin
        int p;
        int s;
        int pick;
        int target;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 37;
        recv_idle_pct = 75;

        // Directed part under the reset configuration.
        push_item(sdss_pkg::OP_NOP, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        push_item(sdss_pkg::OP_TICK, 32'd0, 8'h00, 8'h00);
        push_item(sdss_pkg::OP_TICK, 32'd49, 8'h00, 8'h00);
        push_item(sdss_pkg::OP_TICK, 32'd50, 8'h00, 8'h00);
        push_item(sdss_pkg::OP_TICK, 32'd60, 8'hFF, 8'h00);
        push_item(sdss_pkg::OP_TICK, 32'd110, 8'hFF, 8'h00);
        push_item(sdss_pkg::OP_TICK, 32'd120, 8'h00, 8'h00);
        push_item(sdss_pkg::OP_TICK, 32'd170, 8'h00, 8'h00);
        push_item(sdss_pkg::OP_RESET, 32'd200, 8'h0F, 8'h00);
        push_item(sdss_pkg::OP_FORCE, 32'd200, 8'h00, 8'd5);
        push_item(sdss_pkg::OP_FORCE, 32'd200, 8'h00, 8'd5);
        push_item(sdss_pkg::OP_FORCE, 32'd200, 8'h00, 8'd8);
        push_item(sdss_pkg::OP_FORCE, 32'd200, 8'h00, 8'hFF);
        push_item(sdss_pkg::OP_TICK, 32'd200, 8'hFF, 8'h00);
        push_item(sdss_pkg::OP_TICK, 32'd260, 8'hFF, 8'h00);
        // Debounce across the wrap of the millisecond counter.
        push_item(sdss_pkg::OP_TICK, 32'hFFFF_FFF0, 8'h00, 8'h00);
        push_item(sdss_pkg::OP_TICK, 32'h0000_0021, 8'h00, 8'h00);
        push_item(sdss_pkg::OP_TICK, 32'h0000_0022, 8'h00, 8'h00);
        push_item(sdss_pkg::OP_RESET, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        push_item(sdss_pkg::OP_TICK, 32'h0000_0000, 8'h00, 8'hAA);
        push_item(sdss_pkg::OP_TICK, 32'h0000_0040, 8'h00, 8'h55);

        for (p = 0; p < N_PHASES; p++) begin
            wait_drained();
            if (p < 3) begin
                send_idle_pct = 37;
                recv_idle_pct = 75;
            end else if (p < 6) begin
                send_idle_pct = 75;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                1, 6:    write_reg(sdss_pkg::REG_MODE, 32'(sdss_pkg::MODE_ALL));
                2, 5, 7: write_reg(sdss_pkg::REG_MODE, 32'(sdss_pkg::MODE_SEQ));
                4:       write_reg(sdss_pkg::REG_MODE, 32'(MODE_UNKNOWN));
                default: write_reg(sdss_pkg::REG_MODE, 32'(sdss_pkg::MODE_ANY));
            endcase
            case (p)
                1, 7:    write_reg(sdss_pkg::REG_DEBOUNCE, 32'd0);
                2:       write_reg(sdss_pkg::REG_DEBOUNCE, 32'd3);
                3, 6:    write_reg(sdss_pkg::REG_DEBOUNCE, 32'd65535);
                4:       write_reg(sdss_pkg::REG_DEBOUNCE, 32'd1);
                5:       write_reg(sdss_pkg::REG_DEBOUNCE, 32'd12);
                8:       write_reg(sdss_pkg::REG_DEBOUNCE, 32'd25);
                default: write_reg(sdss_pkg::REG_DEBOUNCE, 32'd50);
            endcase
            if (p == 3) begin
                write_reg(sdss_pkg::REG_ARMING, 32'hFF);
                write_reg(sdss_pkg::REG_LATCHING, 32'hFF);
                write_reg(sdss_pkg::REG_DECOY, 32'hFF);
                write_reg(sdss_pkg::REG_HIGH, 32'hFF);
            end else if (p == 7) begin
                write_reg(sdss_pkg::REG_ARMING, 32'h00);
                write_reg(sdss_pkg::REG_LATCHING, 32'h00);
                write_reg(sdss_pkg::REG_DECOY, 32'h00);
                write_reg(sdss_pkg::REG_HIGH, 32'h00);
            end else begin
                write_reg(sdss_pkg::REG_ARMING, $urandom_range(255));
                write_reg(sdss_pkg::REG_LATCHING, $urandom_range(255));
                // Keep decoys sparse so that sequences can still complete.
                write_reg(sdss_pkg::REG_DECOY, $urandom & $urandom & 32'hFF);
                write_reg(sdss_pkg::REG_HIGH, $urandom_range(255));
            end
            clock_ms = $urandom;
            target = polls_made + POLLS_PER_PHASE;
            while (polls_made < target) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    // Ordered run over all sensors, now and then with a wrong press.
                    if ($urandom_range(1)) hold_pins(~cfg_high);
                    for (s = 0; s < N_SENSORS; s++)
                        press_sensor(($urandom_range(9) == 0) ? $urandom_range(N_SENSORS - 1)
                                                              : s,
                                     $urandom_range(2) != 0);
                end else if (pick < 55) begin
                    press_sensor($urandom_range(N_SENSORS - 1), $urandom_range(1) != 0);
                end else if (pick < 68) begin
                    chatter($urandom_range(N_SENSORS - 1));
                end else if (pick < 74) begin
                    push_item(sdss_pkg::OP_FORCE, $urandom, 8'($urandom_range(255)),
                              ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                       : 8'($urandom_range(N_SENSORS - 1)));
                end else if (pick < 79) begin
                    pin_state = 8'($urandom_range(255));
                    push_item(sdss_pkg::OP_RESET, clock_ms, pin_state,
                              8'($urandom_range(255)));
                end else if (pick < 83) begin
                    push_item(sdss_pkg::OP_NOP, $urandom, 8'($urandom_range(255)),
                              8'($urandom_range(255)));
                end else if (pick < 89) begin
                    push_item(sdss_pkg::OP_TICK, $urandom, 8'($urandom_range(255)),
                              8'($urandom_range(255)));
                end else begin
                    clock_ms += $urandom_range(2 * cfg_deb + 2);
                    push_tick();
                end
            end
        end

        wait_drained();
        repeat (2 * N_SENSORS + 4) @(posedge i_clk);
        if (expected_reports.size() != 0)
            report_mismatch("results still missing at the end");
        if (mismatches == 0)
            $display("sensor_debounce_sequence_solver regression: pass");
        else
            $display("sensor_debounce_sequence_solver regression: fail");
        $finish;
    end

endmodule

FILE: sensor_debounce_sequence_solver.f
hdl/sdss_pkg.sv
hdl/sdss_lane.sv
hdl/sdss_merge.sv
hdl/sensor_debounce_sequence_solver.sv
test/tb_sensor_debounce_sequence_solver.sv
